[rtl/sublv_pkg.sv]
// Shared types and constants for the bit-level UART.
// Used by sublv_tx, sublv_rx and serial_uart_bit_level; depends on nothing.
package sublv_pkg;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_WCTRL = 3'd1;
    localparam logic [2:0] CMD_WDATA = 3'd2;
    localparam logic [2:0] CMD_RSTAT = 3'd3;
    localparam logic [2:0] CMD_RDATA = 3'd4;

    localparam logic [4:0] RX_START_COUNT = 5'd10;
    localparam logic [4:0] RX_BREAK_COUNT = 5'd11;
    localparam logic [4:0] RX_COUNT_MAX   = 5'd31;
    localparam logic [3:0] TX_FRAME_COUNT = 4'd10;

    localparam logic [4:0] BREAK_THRESHOLD_RESET = 5'd24;

    localparam logic [0:0] REG_BREAK_THRESHOLD = 1'b0;

    typedef struct packed {
        logic       tick;
        logic       wctrl;
        logic       wdata;
        logic       rdata;
        logic [7:0] data;
        logic       line;
    } t_cmd;

    typedef struct packed {
        logic pend_valid;
        logic empty;
        logic level;
        logic int_en;
    } t_tx_stat;

    typedef struct packed {
        logic       full;
        logic [7:0] rx_byte;
        logic [3:0] err;
        logic       par;
        logic       int_en;
    } t_rx_stat;

endpackage

[rtl/sublv_tx.sv]
// Transmitter state of the bit-level UART: pending byte, shifter and settings.
// Depends on sublv_pkg.
module sublv_tx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sublv_pkg::t_cmd     i_cmd,
    output sublv_pkg::t_tx_stat o_stat,
    output sublv_pkg::t_tx_stat o_next
);

    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_byte, n_pend_byte;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_count, n_count;
    logic       r_par, n_par;
    logic       r_level, n_level;
    logic [3:0] r_set, n_set;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_shift      = r_shift;
        n_count      = r_count;
        n_par        = r_par;
        n_level      = r_level;
        n_set        = r_set;
        if (i_cmd.wctrl) begin
            n_set = {i_cmd.data[7], i_cmd.data[4], i_cmd.data[0], i_cmd.data[1]};
        end
        if (i_cmd.wdata) begin
            n_pend_byte  = i_cmd.data;
            n_pend_valid = 1'b1;
        end
        if (i_cmd.tick) begin
            case (r_count)
                4'd2: begin
                    n_level = r_set[2] ? r_par : r_set[1];
                    n_count = 4'd1;
                end
                4'd1: begin
                    n_level = 1'b1;
                    n_count = 4'd0;
                end
                4'd0: begin
                    if (r_set[0]) begin
                        n_level = 1'b0;
                    end else if (r_pend_valid) begin
                        n_level      = 1'b0;
                        n_shift      = r_pend_byte;
                        n_pend_valid = 1'b0;
                        n_count      = sublv_pkg::TX_FRAME_COUNT;
                        n_par        = 1'b0;
                    end
                end
                default: begin
                    n_level = r_shift[0];
                    n_par   = r_par ^ r_shift[0];
                    n_shift = {1'b0, r_shift[7:1]};
                    n_count = r_count - 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_byte  <= 8'd0;
            r_shift      <= 8'd0;
            r_count      <= 4'd0;
            r_par        <= 1'b0;
            r_level      <= 1'b1;
            r_set        <= 4'd0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_byte  <= n_pend_byte;
            r_shift      <= n_shift;
            r_count      <= n_count;
            r_par        <= n_par;
            r_level      <= n_level;
            r_set        <= n_set;
        end
    end

    assign o_stat = '{pend_valid: r_pend_valid, empty: (r_count == 4'd0),
                      level: r_level, int_en: r_set[3]};
    assign o_next = '{pend_valid: n_pend_valid, empty: (n_count == 4'd0),
                      level: n_level, int_en: n_set[3]};

endmodule

[rtl/sublv_rx.sv]
// Receiver state of the bit-level UART: sampler, held byte and error flags.
// Depends on sublv_pkg.
module sublv_rx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sublv_pkg::t_cmd     i_cmd,
    input  logic [4:0]          i_break_threshold,
    output sublv_pkg::t_rx_stat o_stat,
    output sublv_pkg::t_rx_stat o_next
);

    logic       r_full, n_full;
    logic [7:0] r_byte, n_byte;
    logic [8:0] r_shift, n_shift;
    logic [4:0] r_count, n_count;
    logic       r_par, n_par;
    logic [3:0] r_err, n_err;
    logic       r_int_en, n_int_en;

    always_comb begin
        n_full   = r_full;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_count  = r_count;
        n_par    = r_par;
        n_err    = r_err;
        n_int_en = r_int_en;
        if (i_cmd.wctrl) begin
            n_int_en = i_cmd.data[6];
            if (i_cmd.data[3]) begin
                n_err = 4'd0;
            end
        end
        if (i_cmd.rdata) begin
            n_full = 1'b0;
        end
        if (i_cmd.tick) begin
            if (r_count inside {[5'd3:5'd10]}) begin
                n_shift = {1'b0, r_shift[8] | i_cmd.line, r_shift[7:1]};
                n_par   = r_par ^ i_cmd.line;
                n_count = r_count - 5'd1;
            end else if (r_count == 5'd2) begin
                if (r_par != i_cmd.line) begin
                    n_err[3] = 1'b1;
                end
                n_count = 5'd1;
            end else if (r_count == 5'd1) begin
                if (i_cmd.line) begin
                    if (r_full) begin
                        n_err[2] = 1'b1;
                    end
                    n_byte  = r_shift[7:0];
                    n_full  = 1'b1;
                    n_count = 5'd0;
                end else begin
                    n_err[1] = 1'b1;
                    n_count  = sublv_pkg::RX_BREAK_COUNT;
                end
            end else if (r_count == 5'd0) begin
                if (!i_cmd.line) begin
                    n_count = sublv_pkg::RX_START_COUNT;
                    n_par   = 1'b0;
                    n_shift = 9'd0;
                end
            end else begin
                if (!i_cmd.line) begin
                    if (r_count >= i_break_threshold) begin
                        n_err[0] = 1'b1;
                    end
                    if (r_count < sublv_pkg::RX_COUNT_MAX) begin
                        n_count = r_count + 5'd1;
                    end
                end else begin
                    n_count = 5'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= 1'b0;
            r_byte   <= 8'd0;
            r_shift  <= 9'd0;
            r_count  <= 5'd0;
            r_par    <= 1'b0;
            r_err    <= 4'd0;
            r_int_en <= 1'b0;
        end else begin
            r_full   <= n_full;
            r_byte   <= n_byte;
            r_shift  <= n_shift;
            r_count  <= n_count;
            r_par    <= n_par;
            r_err    <= n_err;
            r_int_en <= n_int_en;
        end
    end

    assign o_stat = '{full: r_full, rx_byte: r_byte, err: r_err, par: r_par,
                      int_en: r_int_en};
    assign o_next = '{full: n_full, rx_byte: n_byte, err: n_err, par: n_par,
                      int_en: n_int_en};

endmodule

[rtl/serial_uart_bit_level.sv]
// Top level of the bit-level UART: input register, command decode, result register, APB port.
// Depends on sublv_pkg, sublv_tx and sublv_rx.
//
//   Channel   Direction  Handshake                  Payload
//   in        to block   i_in_valid / o_in_ready    i_command, i_data_byte, i_line_level
//   out       from block o_out_valid / i_out_ready  o_read_value, o_tx_line, o_irq
//   cfg       to block   psel, penable, pready      paddr, pwdata, pwrite, prdata
//
// An item is held in the input register and is then processed into the
// result register once that register is free or its result is being taken.
// One item is taken every cycle while results are taken; the input register and
// the result register together hold two items when the output stalls.
// Reset is synchronous and active low and resets valid flags, threshold and tx/rx state.
module serial_uart_bit_level (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_line_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_value,
    output logic        o_tx_line,
    output logic        o_irq,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_in_valid;
    logic [2:0]          r_command;
    logic [7:0]          r_data_byte;
    logic                r_line_level;
    logic                r_out_valid;
    logic [7:0]          r_read_value;
    logic                r_tx_line;
    logic                r_irq;
    logic [4:0]          r_break_threshold;
    logic                advance;
    logic                cfg_write;
    logic [7:0]          n_read_value;
    sublv_pkg::t_cmd     cmd;
    sublv_pkg::t_tx_stat tx_stat, tx_next;
    sublv_pkg::t_rx_stat rx_stat, rx_next;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;

    assign cmd.tick  = advance && (r_command == sublv_pkg::CMD_TICK);
    assign cmd.wctrl = advance && (r_command == sublv_pkg::CMD_WCTRL);
    assign cmd.wdata = advance && (r_command == sublv_pkg::CMD_WDATA);
    assign cmd.rdata = advance && (r_command == sublv_pkg::CMD_RDATA);
    assign cmd.data  = r_data_byte;
    assign cmd.line  = r_line_level;

    sublv_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (tx_stat),
        .o_next  (tx_next)
    );

    sublv_rx u_rx (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_break_threshold (r_break_threshold),
        .o_stat            (rx_stat),
        .o_next            (rx_next)
    );

    always_comb begin
        case (r_command)
            sublv_pkg::CMD_RSTAT: begin
                n_read_value = {!tx_stat.pend_valid, rx_stat.full, tx_stat.empty,
                                rx_stat.err, rx_stat.par};
            end
            sublv_pkg::CMD_RDATA: begin
                n_read_value = rx_stat.full ? rx_stat.rx_byte : 8'd0;
            end
            default: begin
                n_read_value = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_break_threshold <= sublv_pkg::BREAK_THRESHOLD_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write && (paddr[2] == sublv_pkg::REG_BREAK_THRESHOLD)) begin
                r_break_threshold <= pwdata[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command    <= i_command;
            r_data_byte  <= i_data_byte;
            r_line_level <= i_line_level;
        end
        if (advance) begin
            r_read_value <= n_read_value;
            r_tx_line    <= tx_next.level;
            r_irq        <= (!tx_next.pend_valid && tx_next.int_en) ||
                            (rx_next.full && rx_next.int_en);
        end
    end

    assign prdata = (paddr[2] == sublv_pkg::REG_BREAK_THRESHOLD) ?
                    {27'd0, r_break_threshold} : 32'd0;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_tx_line    = r_tx_line;
    assign o_irq        = r_irq;

`ifndef SYNTHESIS
    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed item did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input held off while a stage was free");

    a_read_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_command != sublv_pkg::CMD_RSTAT &&
         r_command != sublv_pkg::CMD_RDATA) |=> (o_read_value == 8'd0))
        else $error("nonzero read value for a non-read item");

    a_rx_full_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rdata && !cmd.tick |=> !rx_stat.full)
        else $error("received byte still held after a data read");
`endif

endmodule

[bench/serial_uart_bit_level_test.sv]
// Testbench for serial_uart_bit_level: random and directed items on the valid/ready channel,
// break threshold set over the APB port, every result checked against a behavioral model.
// Depends on sublv_pkg and the serial_uart_bit_level RTL.
module serial_uart_bit_level_test;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;

    typedef struct packed {
        logic [7:0] value;
        logic       ln;
        logic       irq;
    } t_uart_result;

    class t_uart_scoreboard;
        logic [4:0] break_limit;
        logic       tx_has_byte, tx_out, tx_par;
        logic [7:0] tx_next_byte, tx_sr;
        logic [3:0] tx_left;
        logic       ctl_tx_irq, ctl_par_en, ctl_par_bit, ctl_break;
        logic       rx_has_byte, rx_par, rx_irq_en;
        logic [7:0] rx_held, rx_sr;
        logic [4:0] rx_left;
        logic       err_parity, err_overrun, err_frame, err_break;
        t_uart_result awaited[$];
        int mismatches;

        function new();
            break_limit = sublv_pkg::BREAK_THRESHOLD_RESET;
            tx_has_byte = 1'b0; tx_out = 1'b1; tx_par = 1'b0;
            tx_next_byte = 8'h00; tx_sr = 8'h00; tx_left = 4'd0;
            ctl_tx_irq = 1'b0; ctl_par_en = 1'b0; ctl_par_bit = 1'b0; ctl_break = 1'b0;
            rx_has_byte = 1'b0; rx_par = 1'b0; rx_irq_en = 1'b0;
            rx_held = 8'h00; rx_sr = 8'h00; rx_left = 5'd0;
            err_parity = 1'b0; err_overrun = 1'b0; err_frame = 1'b0; err_break = 1'b0;
            mismatches = 0;
        endfunction

        function void set_break_limit(logic [4:0] lim);
            break_limit = lim;
        endfunction

        function bit drained();
            return awaited.size() == 0;
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch on %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        function void note_item(logic [2:0] cmd, logic [7:0] d, logic ln);
            t_uart_result res;
            res.value = 8'h00;
            case (cmd)
                sublv_pkg::CMD_TICK: begin
                    case (tx_left)
                        4'd2: begin
                            tx_out = ctl_par_en ? tx_par : ctl_par_bit;
                            tx_left = 4'd1;
                        end
                        4'd1: begin
                            tx_out = 1'b1;
                            tx_left = 4'd0;
                        end
                        4'd0: begin
                            if (ctl_break) begin
                                tx_out = 1'b0;
                            end else if (tx_has_byte) begin
                                tx_out = 1'b0;
                                tx_sr = tx_next_byte;
                                tx_has_byte = 1'b0;
                                tx_left = sublv_pkg::TX_FRAME_COUNT;
                                tx_par = 1'b0;
                            end
                        end
                        default: begin
                            tx_out = tx_sr[0];
                            tx_par = tx_par ^ tx_sr[0];
                            tx_sr = tx_sr >> 1;
                            tx_left = tx_left - 4'd1;
                        end
                    endcase
                    if (rx_left >= 5'd3 && rx_left <= sublv_pkg::RX_START_COUNT) begin
                        rx_sr = {ln, rx_sr[7:1]};
                        rx_par = rx_par ^ ln;
                        rx_left = rx_left - 5'd1;
                    end else if (rx_left == 5'd2) begin
                        if (rx_par != ln) err_parity = 1'b1;
                        rx_left = 5'd1;
                    end else if (rx_left == 5'd1) begin
                        if (ln) begin
                            if (rx_has_byte) err_overrun = 1'b1;
                            rx_held = rx_sr;
                            rx_has_byte = 1'b1;
                            rx_left = 5'd0;
                        end else begin
                            err_frame = 1'b1;
                            rx_left = sublv_pkg::RX_BREAK_COUNT;
                        end
                    end else if (rx_left == 5'd0) begin
                        if (!ln) begin
                            rx_left = sublv_pkg::RX_START_COUNT;
                            rx_par = 1'b0;
                            rx_sr = 8'h00;
                        end
                    end else if (!ln) begin
                        if (rx_left >= break_limit) err_break = 1'b1;
                        if (rx_left < sublv_pkg::RX_COUNT_MAX) rx_left = rx_left + 5'd1;
                    end else begin
                        rx_left = 5'd0;
                    end
                end
                sublv_pkg::CMD_WCTRL: begin
                    ctl_tx_irq = d[7];
                    rx_irq_en = d[6];
                    ctl_par_en = d[4];
                    ctl_par_bit = d[0];
                    ctl_break = d[1];
                    if (d[3]) begin
                        err_parity = 1'b0; err_overrun = 1'b0;
                        err_frame = 1'b0; err_break = 1'b0;
                    end
                end
                sublv_pkg::CMD_WDATA: begin
                    tx_next_byte = d;
                    tx_has_byte = 1'b1;
                end
                sublv_pkg::CMD_RSTAT: begin
                    res.value = {~tx_has_byte, rx_has_byte, tx_left == 4'd0, err_parity,
                                 err_overrun, err_frame, err_break, rx_par};
                end
                sublv_pkg::CMD_RDATA: begin
                    if (rx_has_byte) begin
                        res.value = rx_held;
                        rx_has_byte = 1'b0;
                    end
                end
                default: ;
            endcase
            res.ln = tx_out;
            res.irq = (~tx_has_byte & ctl_tx_irq) | (rx_has_byte & rx_irq_en);
            awaited.push_back(res);
        endfunction

        function void check_result(logic [7:0] value, logic ln, logic irq);
            t_uart_result want;
            if (awaited.size() == 0) begin
                report("result with none outstanding", 0, value);
                return;
            end
            want = awaited.pop_front();
            if (value !== want.value) report("read value", want.value, value);
            if (ln !== want.ln) report("tx line", want.ln, ln);
            if (irq !== want.irq) report("irq", want.irq, irq);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_command = sublv_pkg::CMD_TICK;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_line_level = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_value;
    logic        o_tx_line;
    logic        o_irq;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_uart_scoreboard board;
    logic line_bits[$];
    int gap_pct = 12;
    int stall_pct = 70;

    serial_uart_bit_level uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_data_byte(i_data_byte), .i_line_level(i_line_level),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_read_value(o_read_value), .o_tx_line(o_tx_line), .o_irq(o_irq),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_read_value, o_tx_line, o_irq);
        end
    end

    task automatic push_item(input logic [2:0] cmd, input logic [7:0] d, input logic ln);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_data_byte <= d;
        i_line_level <= ln;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(cmd, d, ln);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (!board.drained());
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_break_limit(input logic [4:0] lim);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * sublv_pkg::REG_BREAK_THRESHOLD);
        pwdata <= {27'd0, lim};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_break_limit(lim);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {27'd0, lim}) board.report("break threshold readback", lim, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic directed_items();
        int i;
        logic [10:0] frame;
        frame = {1'b1, 1'b1, 8'hFF, 1'b0};
        push_item(sublv_pkg::CMD_RSTAT, 8'h00, 1'b0);
        push_item(sublv_pkg::CMD_RDATA, 8'hFF, 1'b1);
        push_item(CMD_SPARE_FIRST, 8'hFF, 1'b1);
        push_item(CMD_SPARE_FIRST + 3'd1, 8'h00, 1'b0);
        push_item(CMD_SPARE_FIRST + 3'd2, 8'hA5, 1'b1);
        // Break while idle: the written byte must stay pending across the tick.
        push_item(sublv_pkg::CMD_WCTRL, 8'hD3, 1'b0);
        push_item(sublv_pkg::CMD_WDATA, 8'hFF, 1'b0);
        push_item(sublv_pkg::CMD_TICK, 8'h00, 1'b1);
        push_item(sublv_pkg::CMD_RSTAT, 8'h5A, 1'b0);
        push_item(sublv_pkg::CMD_WDATA, 8'h00, 1'b1);
        push_item(sublv_pkg::CMD_WCTRL, 8'h08, 1'b1);
        // One transmit frame alongside a received frame whose parity bit is wrong.
        for (i = 0; i < 11; i++) begin
            push_item(sublv_pkg::CMD_TICK, 8'($urandom), frame[i]);
        end
        push_item(sublv_pkg::CMD_RSTAT, 8'hFF, 1'b1);
        push_item(sublv_pkg::CMD_RDATA, 8'h00, 1'b0);
    endtask

    task automatic random_items(input int count);
        int done, r, n;
        logic [7:0] d, fb;
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            d = 8'($urandom);
            if (r < 60) begin
                if (line_bits.size() == 0) begin
                    n = $urandom_range(99);
                    if (n < 30) begin
                        fb = 8'($urandom);
                        line_bits.push_back(1'b0);
                        for (n = 0; n < 8; n++) line_bits.push_back(fb[n]);
                        line_bits.push_back((^fb) ^ ($urandom_range(9) == 0));
                        line_bits.push_back($urandom_range(11) != 0);
                    end else if (n < 36) begin
                        repeat ($urandom_range(45, 11)) line_bits.push_back(1'b0);
                    end else begin
                        line_bits.push_back(($urandom_range(9) == 0) ? 1'($urandom) : 1'b1);
                    end
                end
                push_item(sublv_pkg::CMD_TICK, d, line_bits.pop_front());
            end else if (r < 70) begin
                push_item(sublv_pkg::CMD_WDATA, d, 1'($urandom));
            end else if (r < 76) begin
                if ($urandom_range(7) != 0) d[1] = 1'b0;
                if ($urandom_range(2) != 0) d[3] = 1'b0;
                push_item(sublv_pkg::CMD_WCTRL, d, 1'($urandom));
            end else if (r < 88) begin
                push_item(sublv_pkg::CMD_RSTAT, d, 1'($urandom));
            end else if (r < 96) begin
                push_item(sublv_pkg::CMD_RDATA, d, 1'($urandom));
            end else begin
                push_item(3'($urandom_range(7, CMD_SPARE_FIRST)), d, 1'($urandom));
            end
            done++;
        end
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        settle();
        write_break_limit(5'd12);
        random_items(250);
        settle();

        write_break_limit(5'd30);
        gap_pct = 70;
        stall_pct = 12;
        random_items(250);
        settle();

        write_break_limit(5'($urandom_range(30, 12)));
        gap_pct = 0;
        stall_pct = 0;
        random_items(250);
        settle();

        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/sublv_pkg.sv
rtl/sublv_tx.sv
rtl/sublv_rx.sv
rtl/serial_uart_bit_level.sv
bench/serial_uart_bit_level_test.sv
